/* rtl/core/tcgr_pkg.sv */
// Shared types, constants and tables of the text console glyph renderer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package tcgr_pkg;

    localparam int MAX_GLYPH_ROWS_DEF = 32;
    localparam int GLYPH_COUNT_DEF    = 256;
    localparam int TAB_STOP           = 8;
    localparam int OUT_LIMIT          = 32;
    localparam int Q_DEPTH            = 4;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    localparam logic OP_PRINT = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    localparam logic [2:0] REG_COLS = 3'd0;
    localparam logic [2:0] REG_ROWS = 3'd1;
    localparam logic [2:0] REG_PPL  = 3'd2;
    localparam logic [2:0] REG_GW   = 3'd3;
    localparam logic [2:0] REG_GH   = 3'd4;

    localparam logic [8:0]  RST_COLS = 9'd80;
    localparam logic [8:0]  RST_ROWS = 9'd25;
    localparam logic [13:0] RST_PPL  = 14'd640;
    localparam logic [4:0]  RST_GW   = 5'd8;
    localparam logic [5:0]  RST_GH   = 6'd16;

    // clamped configuration as the datapath uses it
    typedef struct packed {
        logic [8:0]  cols;
        logic [8:0]  rows;
        logic [13:0] ppl;
        logic [4:0]  gw;
        logic [5:0]  gh;
        logic [15:0] mask;
    } t_cfg;

    // one queued job: a font row load or a glyph draw
    typedef struct packed {
        logic        is_load;
        logic [15:0] bits;
        logic [24:0] pix;
    } t_job;

    typedef logic [8:0] t_tab_tbl [256];

    function automatic t_tab_tbl f_tab_table();
        t_tab_tbl t;
        for (int i = 0; i < 256; i++) begin
            t[i] = 9'((i / TAB_STOP + 1) * TAB_STOP);
        end
        return t;
    endfunction

    // next tab stop for each cursor column
    localparam t_tab_tbl TAB_NEXT = f_tab_table();

endpackage

/* rtl/core/text_console_glyph_renderer_top.sv */
// Top level of the text console glyph renderer: register file, front end, queue, back end.
// Depends on tcgr_pkg, tcgr_front, tcgr_queue and tcgr_back.
//
// Usage: the input channel (i_in_valid / o_in_ready) carries one beat per print or
// font load. A load writes one 16-bit row of one glyph into the font store. A print
// of a drawable character produces glyph_height output beats (o_out_valid /
// i_out_ready), one per glyph row, with the row's pixel offset and bits; the last
// row carries o_last. CR, LF, BS, TAB, NUL and prints below the bottom line only
// move the cursor and produce nothing.
// Timing: a load or a drawing print passes the front end's multiply, sum and push states,
// holding in push while the queue is full; a cursor-only beat leaves the front end idle.
// The back end reads one font row per cycle from its single-port store unless the output
// stalls (glyph_height is 16 at reset); each row passes the read and output registers.
// Next job is taken after the last row is read; a 4-entry queue lets the front run ahead.
// Reset: cursor at column 0, line 0, registers at their reset values; the font
// store is not cleared. A stalled receiver holds the output beat; the back end and
// then the queue fill, after which o_in_ready stays low until space frees. The user must
// write registers over the APB port only while idle; the block does not enforce this.
`timescale 1ns / 1ps

module text_console_glyph_renderer_top
    import tcgr_pkg::*;
#(
    parameter int MAX_GLYPH_ROWS = MAX_GLYPH_ROWS_DEF,
    parameter int GLYPH_COUNT    = GLYPH_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [7:0]  i_character,
    input  logic [4:0]  i_load_row,
    input  logic [15:0] i_load_bits,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [24:0] o_pixel_index,
    output logic [15:0] o_row_bits,
    output logic        o_last
);

    localparam int DEPTH = GLYPH_COUNT * MAX_GLYPH_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int QW    = $bits(t_job) + AW;
    localparam logic [5:0] GH_HI = 6'((MAX_GLYPH_ROWS < OUT_LIMIT) ? MAX_GLYPH_ROWS : OUT_LIMIT);

    logic [8:0]    r_cols;
    logic [8:0]    r_rows;
    logic [13:0]   r_ppl;
    logic [4:0]    r_gw;
    logic [5:0]    r_gh;
    logic          wr_en;
    t_cfg          cfg;

    logic          fq_valid;
    logic          fq_ready;
    t_job          f_job;
    logic [AW-1:0] f_addr;
    logic          qb_valid;
    logic          qb_ready;
    logic [QW-1:0] qb_data;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= RST_COLS;
            r_rows <= RST_ROWS;
            r_ppl  <= RST_PPL;
            r_gw   <= RST_GW;
            r_gh   <= RST_GH;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                REG_COLS: r_cols <= pwdata[8:0];
                REG_ROWS: r_rows <= pwdata[8:0];
                REG_PPL:  r_ppl  <= pwdata[13:0];
                REG_GW:   r_gw   <= pwdata[4:0];
                REG_GH:   r_gh   <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_COLS: prdata = {23'b0, r_cols};
            REG_ROWS: prdata = {23'b0, r_rows};
            REG_PPL:  prdata = {18'b0, r_ppl};
            REG_GW:   prdata = {27'b0, r_gw};
            REG_GH:   prdata = {26'b0, r_gh};
            default:  prdata = '0;
        endcase
    end

    // clamp each register into its legal range
    always_comb begin
        cfg.cols = (r_cols == '0) ? 9'd1 : ((r_cols > 9'd256) ? 9'd256 : r_cols);
        cfg.rows = (r_rows == '0) ? 9'd1 : ((r_rows > 9'd256) ? 9'd256 : r_rows);
        cfg.ppl  = (r_ppl == '0) ? 14'd1 : ((r_ppl > 14'd8192) ? 14'd8192 : r_ppl);
        cfg.gw   = (r_gw == '0) ? 5'd1 : ((r_gw > 5'd16) ? 5'd16 : r_gw);
        cfg.gh   = (r_gh == '0) ? 6'd1 : ((r_gh > GH_HI) ? GH_HI : r_gh);
        cfg.mask = 16'hFFFF << (5'd16 - cfg.gw);
    end

    tcgr_front #(
        .MAX_GLYPH_ROWS(MAX_GLYPH_ROWS),
        .GLYPH_COUNT   (GLYPH_COUNT),
        .AW            (AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_operation (i_operation),
        .i_character (i_character),
        .i_load_row  (i_load_row),
        .i_load_bits (i_load_bits),
        .o_job_valid (fq_valid),
        .i_job_ready (fq_ready),
        .o_job       (f_job),
        .o_job_addr  (f_addr)
    );

    tcgr_queue #(
        .WIDTH(QW),
        .DEPTH(Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_data  ({f_addr, f_job}),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_data  (qb_data)
    );

    tcgr_back #(
        .AW   (AW),
        .DEPTH(DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_job_valid   (qb_valid),
        .o_job_ready   (qb_ready),
        .i_job         (qb_data[$bits(t_job)-1:0]),
        .i_job_addr    (qb_data[QW-1:$bits(t_job)]),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_pixel_index (o_pixel_index),
        .o_row_bits    (o_row_bits),
        .o_last        (o_last)
    );

endmodule

/* rtl/core/tcgr_queue.sv */
// Small first-in first-out job queue between front and back end.
// Depends on tcgr_pkg for the default depth.
`timescale 1ns / 1ps

module tcgr_queue
    import tcgr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [PW:0]   FULL_CNT = (PW + 1)'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [PW:0]      r_count;
    logic             wr;
    logic             rd;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr      = i_valid && o_ready;
    assign rd      = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* rtl/core/tcgr_front.sv */
// Front end: accepts beats, keeps the cursor, computes font addresses and row offsets.
// Depends on tcgr_pkg (config struct, job struct, character codes, tab table).
`timescale 1ns / 1ps

module tcgr_front
    import tcgr_pkg::*;
#(
    parameter int MAX_GLYPH_ROWS = MAX_GLYPH_ROWS_DEF,
    parameter int GLYPH_COUNT    = GLYPH_COUNT_DEF,
    parameter int AW             = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_operation,
    input  logic [7:0]    i_character,
    input  logic [4:0]    i_load_row,
    input  logic [15:0]   i_load_bits,
    output logic          o_job_valid,
    input  logic          i_job_ready,
    output t_job          o_job,
    output logic [AW-1:0] o_job_addr
);

    localparam int GB = $clog2(GLYPH_COUNT);
    localparam logic [9:0] GC10 = 10'(GLYPH_COUNT);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_SUM  = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate       r_state;
    t_fstate       n_state;
    logic [7:0]    r_col;
    logic [7:0]    n_col;
    logic [8:0]    r_line;
    logic [8:0]    n_line;

    logic          r_is_load;
    logic [GB-1:0] r_glyph;
    logic [4:0]    r_row;
    logic [15:0]   r_bits;
    logic [8:0]    r_dline;
    logic [7:0]    r_dcol;
    logic [14:0]   r_lgh;
    logic [12:0]   r_cgw;
    logic [AW-1:0] r_addr;
    logic [24:0]   r_pix;

    logic          accept;
    logic          draw;
    logic          load_ok;
    logic [8:0]    d_line;
    logic [7:0]    d_col;
    logic [8:0]    c9;
    logic [8:0]    nc;
    logic [8:0]    tab;
    logic [8:0]    l9;
    logic [9:0]    ch10;
    logic [9:0]    glyph10;
    logic [28:0]   prod;

    function automatic logic [8:0] f_next_line(input logic [8:0] line, input logic [8:0] rows);
        logic [9:0] n;
        n = {1'b0, line} + 10'd1;
        return (n > {1'b0, rows}) ? rows : n[8:0];
    endfunction

    assign o_ready     = (r_state == F_IDLE);
    assign accept      = i_valid && o_ready;
    assign load_ok     = (32'(i_load_row) < MAX_GLYPH_ROWS);
    assign ch10        = {2'b00, i_character};
    assign glyph10     = (ch10 < GC10) ? ch10 : ch10 - GC10;
    assign prod        = 29'(r_lgh) * 29'(i_cfg.ppl);
    assign o_job_valid = (r_state == F_PUSH);
    assign o_job       = '{is_load: r_is_load, bits: r_bits, pix: r_pix};
    assign o_job_addr  = r_addr;

    // cursor movement for a print beat
    always_comb begin
        n_col  = r_col;
        n_line = r_line;
        draw   = 1'b0;
        d_line = r_line;
        d_col  = r_col;
        c9     = {1'b0, r_col};
        nc     = '0;
        tab    = TAB_NEXT[r_col];
        l9     = r_line;
        unique case (i_character)
            CH_CR: begin
                n_col = '0;
            end
            CH_LF: begin
                n_col  = '0;
                n_line = f_next_line(r_line, i_cfg.rows);
            end
            CH_BS: begin
                if (r_col != '0) begin
                    n_col = r_col - 8'd1;
                end
            end
            CH_TAB: begin
                if (tab >= i_cfg.cols) begin
                    nc = tab - i_cfg.cols;
                    if (nc >= i_cfg.cols) begin
                        nc = '0;
                    end
                    n_line = f_next_line(r_line, i_cfg.rows);
                end else begin
                    nc = tab;
                end
                n_col = nc[7:0];
            end
            CH_NUL: begin
                n_col = r_col;
            end
            default: begin
                if (c9 >= i_cfg.cols) begin
                    c9 = '0;
                    l9 = f_next_line(l9, i_cfg.rows);
                end
                draw   = (l9 < i_cfg.rows);
                d_line = l9;
                d_col  = c9[7:0];
                nc     = c9 + 9'd1;
                if (nc >= i_cfg.cols) begin
                    nc = '0;
                    l9 = f_next_line(l9, i_cfg.rows);
                end
                n_col  = nc[7:0];
                n_line = l9;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_LOAD) begin
                        n_state = load_ok ? F_MUL : F_IDLE;
                    end else begin
                        n_state = draw ? F_MUL : F_IDLE;
                    end
                end
            end
            F_MUL:  n_state = F_SUM;
            F_SUM:  n_state = F_PUSH;
            F_PUSH: n_state = i_job_ready ? F_IDLE : F_PUSH;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_col   <= '0;
            r_line  <= '0;
        end else begin
            r_state <= n_state;
            if (accept && i_operation == OP_PRINT) begin
                r_col  <= n_col;
                r_line <= n_line;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_load <= (i_operation == OP_LOAD);
            r_glyph   <= glyph10[GB-1:0];
            r_row     <= (i_operation == OP_LOAD) ? i_load_row : 5'd0;
            r_bits    <= i_load_bits;
            r_dline   <= d_line;
            r_dcol    <= d_col;
        end
        if (r_state == F_MUL) begin
            r_lgh  <= {6'b0, r_dline} * {9'b0, i_cfg.gh};
            r_cgw  <= {5'b0, r_dcol} * {8'b0, i_cfg.gw};
            r_addr <= AW'(32'(r_glyph) * MAX_GLYPH_ROWS + 32'(r_row));
        end
        if (r_state == F_SUM) begin
            r_pix <= prod[24:0] + 25'(r_cgw);
        end
    end

endmodule

/* rtl/core/tcgr_back.sv */
// Back end: font store, glyph row sequencer and output register.
// Depends on tcgr_pkg (config struct, job struct).
`timescale 1ns / 1ps

module tcgr_back
    import tcgr_pkg::*;
#(
    parameter int AW    = 13,
    parameter int DEPTH = 8192
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    input  t_job          i_job,
    input  logic [AW-1:0] i_job_addr,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [24:0]   o_pixel_index,
    output logic [15:0]   o_row_bits,
    output logic          o_last
);

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_DRAW = 2'b10
    } t_bstate;

    logic [15:0]   r_font [DEPTH];
    t_bstate       r_state;
    logic [AW-1:0] r_addr;
    logic [24:0]   r_pix;
    logic [5:0]    r_left;

    logic          r_rd_valid;
    logic [15:0]   r_rdata;
    logic [24:0]   r_rd_pix;
    logic          r_rd_last;

    logic          r_out_valid;
    logic [24:0]   r_out_pix;
    logic [15:0]   r_out_bits;
    logic          r_out_last;

    logic          pop;
    logic          issue;
    logic          move;

    assign o_job_ready   = (r_state == B_IDLE);
    assign pop           = i_job_valid && o_job_ready;
    assign move          = r_rd_valid && (!r_out_valid || i_ready);
    assign issue         = (r_state == B_DRAW) && (!r_rd_valid || move);
    assign o_valid       = r_out_valid;
    assign o_pixel_index = r_out_pix;
    assign o_row_bits    = r_out_bits;
    assign o_last        = r_out_last;

    always_ff @(posedge i_clk) begin
        if (pop && i_job.is_load) begin
            r_font[i_job_addr] <= i_job.bits;
        end
        if (issue) begin
            r_rdata <= r_font[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (pop && !i_job.is_load) begin
                        r_state <= B_DRAW;
                    end
                end
                B_DRAW: begin
                    if (issue && r_left == 6'd1) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
            if (issue) begin
                r_rd_valid <= 1'b1;
            end else if (move) begin
                r_rd_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_addr <= i_job_addr;
            r_pix  <= i_job.pix;
            r_left <= i_cfg.gh;
        end else if (issue) begin
            r_addr <= r_addr + 1'b1;
            r_pix  <= r_pix + {11'b0, i_cfg.ppl};
            r_left <= r_left - 6'd1;
        end
        if (issue) begin
            r_rd_pix  <= r_pix;
            r_rd_last <= (r_left == 6'd1);
        end
        if (move) begin
            r_out_pix  <= r_rd_pix;
            r_out_bits <= r_rdata & i_cfg.mask;
            r_out_last <= r_rd_last;
        end
    end

endmodule

/* rtl/core/tcgr_checker.sv */
// Port-level checks for the text console glyph renderer, bound to the top level.
// Depends on tcgr_pkg and text_console_glyph_renderer_top.
`timescale 1ns / 1ps

module tcgr_checker
    import tcgr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [4:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_operation,
    input logic [7:0]  i_character,
    input logic [4:0]  i_load_row,
    input logic [15:0] i_load_bits,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [24:0] o_pixel_index,
    input logic [15:0] o_row_bits,
    input logic        o_last
);

    // out of reset: nothing pending, input side open
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("block not idle after reset");

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_pixel_index) && $stable(o_row_bits) && $stable(o_last)))
        else $error("output beat dropped or changed under stall");

    // column register reads back what was written
    a_cols_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && paddr[4:2] == REG_COLS)
            ##1 (paddr[4:2] == REG_COLS) |-> (prdata == {23'b0, $past(pwdata[8:0])}))
        else $error("column register readback mismatch");

    // the port never inserts wait states
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable) |-> pready)
        else $error("pready low during access");

endmodule

bind text_console_glyph_renderer_top tcgr_checker u_checker (.*);

/* dv/tb_top.sv */
// Self-checking bench for text_console_glyph_renderer_top: glyph loads, prints and cursor codes.
// A behavioral glyph predictor checks every output beat; depends on tcgr_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_top;
    import tcgr_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 64;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          SCRIPT_LEN   = 21;
    localparam int unsigned GH_CAP       =
        (OUT_LIMIT < MAX_GLYPH_ROWS_DEF) ? OUT_LIMIT : MAX_GLYPH_ROWS_DEF;

    typedef struct packed {
        logic [24:0] pix;
        logic [15:0] bits;
        logic        last;
    } t_glyph_row;

    typedef struct packed {
        logic        op;
        logic [7:0]  ch;
        logic [4:0]  row;
        logic [15:0] bits;
        logic        typed;
        logic [24:0] pix;
    } t_script_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [4:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic        i_operation = OP_PRINT;
    logic [7:0]  i_character = '0;
    logic [4:0]  i_load_row  = '0;
    logic [15:0] i_load_bits = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [24:0] o_pixel_index;
    logic [15:0] o_row_bits;
    logic        o_last;

    text_console_glyph_renderer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_character   (i_character),
        .i_load_row    (i_load_row),
        .i_load_bits   (i_load_bits),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_index (o_pixel_index),
        .o_row_bits    (o_row_bits),
        .o_last        (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [8:0]  cfg_cols;
    logic [8:0]  cfg_rows;
    logic [13:0] cfg_ppl;
    logic [4:0]  cfg_gw;
    logic [5:0]  cfg_gh;
    logic [7:0]  cur_col;
    logic [8:0]  cur_line;
    logic [15:0] font_rows [8192];
    bit          font_known [8192];

    t_glyph_row  expected_rows [$];
    logic [7:0]  glyph_pool [$];
    bit          in_pool [256];

    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int          burst_left     = 0;
    bit          gaps_on        = 1'b1;
    bit          pix_override   = 1'b0;
    logic [24:0] override_pix   = '0;
    logic        hold_go        = 1'b0;
    bit          hold_served    = 1'b0;

    function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int unsigned eff_cols();
        return clamp_u(cfg_cols, 1, 256);
    endfunction

    function automatic int unsigned eff_rows();
        return clamp_u(cfg_rows, 1, 256);
    endfunction

    function automatic int unsigned eff_gh();
        return clamp_u(cfg_gh, 1, GH_CAP);
    endfunction

    function automatic void advance_line();
        int unsigned n;
        n = cur_line + 1;
        cur_line = (n > eff_rows()) ? 9'(eff_rows()) : 9'(n);
    endfunction

    function automatic bit is_cursor_code(logic [7:0] ch);
        return ch inside {CH_CR, CH_LF, CH_BS, CH_TAB, CH_NUL};
    endfunction

    // would a print of ch read the font store right now
    function automatic bit glyph_drawn(logic [7:0] ch);
        int unsigned line_at;
        line_at = cur_line;
        if (is_cursor_code(ch)) return 1'b0;
        if (cur_col >= eff_cols()) line_at = (cur_line + 1 > eff_rows()) ? eff_rows() : cur_line + 1;
        return line_at < eff_rows();
    endfunction

    function automatic void render_beat(logic op, logic [7:0] ch, logic [4:0] row,
                                        logic [15:0] bits);
        int unsigned       cols;
        int unsigned       ppl;
        int unsigned       gw;
        int unsigned       gh;
        int unsigned       nc;
        logic [15:0]       mask;
        longint unsigned   p;
        t_glyph_row        r;
        cols = eff_cols();
        ppl  = clamp_u(cfg_ppl, 1, 8192);
        gw   = clamp_u(cfg_gw, 1, 16);
        gh   = eff_gh();
        if (op == OP_LOAD) begin
            font_rows[{ch, row}]  = bits;
            font_known[{ch, row}] = 1'b1;
            return;
        end
        case (ch)
            CH_CR: cur_col = '0;
            CH_LF: begin
                cur_col = '0;
                advance_line();
            end
            CH_BS: if (cur_col != 0) cur_col = cur_col - 8'd1;
            CH_TAB: begin
                nc = (cur_col / TAB_STOP + 1) * TAB_STOP;
                if (nc >= cols) begin
                    nc = nc - cols;
                    if (nc >= cols) nc = 0;
                    advance_line();
                end
                cur_col = nc[7:0];
            end
            CH_NUL: ;
            default: begin
                if (cur_col >= cols) begin
                    cur_col = '0;
                    advance_line();
                end
                if (cur_line < eff_rows()) begin
                    mask = 16'(32'hFFFF << (16 - gw));
                    for (int unsigned y = 0; y < gh; y++) begin
                        p = (longint'(cur_line) * gh + y) * ppl + longint'(cur_col) * gw;
                        r.pix  = (pix_override && y == 0) ? override_pix : p[24:0];
                        r.bits = font_rows[{ch, 5'(y)}] & mask;
                        r.last = (y + 1 == gh);
                        expected_rows.push_back(r);
                    end
                end
                nc = cur_col + 1;
                if (nc >= cols) begin
                    nc = 0;
                    advance_line();
                end
                cur_col = nc[7:0];
            end
        endcase
    endfunction

    task automatic send_beat(logic op, logic [7:0] ch, logic [4:0] row, logic [15:0] bits);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left  = burst_left - 1;
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_character <= ch;
        i_load_row  <= row;
        i_load_bits <= bits;
        do @(posedge i_clk); while (!o_in_ready);
        render_beat(op, ch, row, bits);
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
        burst_left = 0;
    endtask

    // fills any font row the print is about to read, then prints
    task automatic print_char(logic [7:0] ch);
        int unsigned gh;
        gh = eff_gh();
        if (glyph_drawn(ch)) begin
            for (int unsigned y = 0; y < gh; y++) begin
                if (!font_known[{ch, 5'(y)}]) send_beat(OP_LOAD, ch, 5'(y), 16'($urandom));
            end
        end
        send_beat(OP_PRINT, ch, 5'($urandom), 16'($urandom));
        if (!is_cursor_code(ch) && !in_pool[ch]) begin
            in_pool[ch] = 1'b1;
            glyph_pool.push_back(ch);
        end
    endtask

    function automatic logic [7:0] pick_glyph();
        if (glyph_pool.size() > 0 && $urandom_range(0, 4) != 0)
            return glyph_pool[$urandom_range(0, glyph_pool.size() - 1)];
        return 8'($urandom);
    endfunction

    task automatic apb_write(logic [2:0] idx, int unsigned val);
        logic [31:0] data;
        data = $urandom;
        case (idx)
            REG_COLS: data[8:0]  = val[8:0];
            REG_ROWS: data[8:0]  = val[8:0];
            REG_PPL:  data[13:0] = val[13:0];
            REG_GW:   data[4:0]  = val[4:0];
            default:  data[5:0]  = val[5:0];
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_COLS: cfg_cols = data[8:0];
            REG_ROWS: cfg_rows = data[8:0];
            REG_PPL:  cfg_ppl  = data[13:0];
            REG_GW:   cfg_gw   = data[4:0];
            default:  cfg_gh   = data[5:0];
        endcase
    endtask

    task automatic configure(int unsigned cols, int unsigned rows, int unsigned ppl,
                             int unsigned gw, int unsigned gh);
        stop_sending();
        while (expected_rows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        apb_write(REG_COLS, cols);
        apb_write(REG_ROWS, rows);
        apb_write(REG_PPL, ppl);
        apb_write(REG_GW, gw);
        apb_write(REG_GH, gh);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_items(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                send_beat(OP_LOAD, 8'($urandom), 5'($urandom), 16'($urandom));
            end else if (r < 32) begin
                case ($urandom_range(0, 5))
                    0:       print_char(CH_CR);
                    1:       print_char(CH_LF);
                    2:       print_char(CH_BS);
                    5:       print_char(CH_NUL);
                    default: print_char(CH_TAB);
                endcase
            end else begin
                print_char(pick_glyph());
            end
        end
    endtask

    // receiver: random ready patterns plus one long hold-off
    initial begin
        int stretch;
        int mode;
        stretch = 0;
        mode    = 0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_served) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_served = 1'b1;
            end else begin
                if (stretch == 0) begin
                    mode    = $urandom_range(0, 2);
                    stretch = $urandom_range(1, 60);
                end
                stretch = stretch - 1;
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= 1'($urandom);
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_glyph_row want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_rows.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected beat pixel_index %h row_bits %h last %b",
                         $time, o_pixel_index, o_row_bits, o_last);
            end else begin
                want = expected_rows.pop_front();
                if (o_pixel_index !== want.pix) begin
                    mismatch_count++;
                    $display("%0t: pixel_index expected %h actual %h",
                             $time, want.pix, o_pixel_index);
                end
                if (o_row_bits !== want.bits) begin
                    mismatch_count++;
                    $display("%0t: row_bits expected %h actual %h",
                             $time, want.bits, o_row_bits);
                end
                if (o_last !== want.last) begin
                    mismatch_count++;
                    $display("%0t: last expected %b actual %b", $time, want.last, o_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // directed script; typed pixel index only where it is obvious from the cursor position
    t_script_row script [SCRIPT_LEN] = '{
        '{OP_LOAD,  8'h41,  5'd0,  16'hFFFF, 1'b0, 25'd0},
        '{OP_LOAD,  8'h41,  5'd1,  16'h8001, 1'b0, 25'd0},
        '{OP_LOAD,  8'h41,  5'd31, 16'h0000, 1'b0, 25'd0},
        '{OP_LOAD,  8'hFF,  5'd15, 16'h5AA5, 1'b0, 25'd0},
        '{OP_PRINT, 8'h41,  5'd0,  16'h0000, 1'b1, 25'd0},
        '{OP_PRINT, 8'hFF,  5'd0,  16'h0000, 1'b1, 25'd8},
        '{OP_PRINT, CH_CR,  5'd0,  16'h0000, 1'b0, 25'd0},
        '{OP_PRINT, 8'h01,  5'd0,  16'h0000, 1'b1, 25'd0},
        '{OP_PRINT, CH_BS,  5'd0,  16'h0000, 1'b0, 25'd0},
        '{OP_PRINT, CH_BS,  5'd0,  16'h0000, 1'b0, 25'd0},
        '{OP_PRINT, CH_TAB, 5'd0,  16'h0000, 1'b0, 25'd0},
        '{OP_PRINT, 8'h80,  5'd0,  16'h0000, 1'b1, 25'd64},
        '{OP_PRINT, CH_LF,  5'd0,  16'h0000, 1'b0, 25'd0},
        '{OP_PRINT, 8'h41,  5'd0,  16'h0000, 1'b1, 25'd10240},
        '{OP_PRINT, CH_NUL, 5'd0,  16'h0000, 1'b0, 25'd0},
        '{OP_PRINT, 8'h7F,  5'd0,  16'h0000, 1'b1, 25'd10248},
        '{OP_PRINT, CH_TAB, 5'd0,  16'h0000, 1'b0, 25'd0},
        '{OP_PRINT, 8'h20,  5'd0,  16'h0000, 1'b1, 25'd10304},
        '{OP_PRINT, CH_LF,  5'd0,  16'h0000, 1'b0, 25'd0},
        '{OP_PRINT, CH_LF,  5'd0,  16'h0000, 1'b0, 25'd0},
        '{OP_PRINT, 8'h0C,  5'd0,  16'h0000, 1'b1, 25'd30720}
    };

    initial begin
        cfg_cols = RST_COLS;
        cfg_rows = RST_ROWS;
        cfg_ppl  = RST_PPL;
        cfg_gw   = RST_GW;
        cfg_gh   = RST_GH;
        cur_col  = '0;
        cur_line = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < SCRIPT_LEN; k++) begin
            if (script[k].op == OP_LOAD) begin
                send_beat(OP_LOAD, script[k].ch, script[k].row, script[k].bits);
            end else begin
                pix_override = script[k].typed;
                override_pix = script[k].pix;
                print_char(script[k].ch);
                pix_override = 1'b0;
            end
        end

        // back-pressure: receiver holds off while glyphs keep coming
        configure(RST_COLS, RST_ROWS, RST_PPL, RST_GW, RST_GH);
        hold_go <= 1'b1;
        gaps_on = 1'b0;
        repeat (12) print_char(pick_glyph());
        gaps_on = 1'b1;
        random_items(30);

        // deep lines with the largest geometry, pixel index wraps
        configure(256, 256, 8192, 16, 32);
        while (cur_line < 130) print_char(CH_LF);
        random_items(20);

        configure(5, 200, 37, 3, 5);
        random_items(30);
        configure(3, 200, 1000, 16, 7);
        random_items(15);
        configure(1, 1, 1, 1, 1);
        random_items(12);
        configure(0, 0, 0, 0, 0);
        random_items(8);
        configure(0, 220, 0, 0, 0);
        random_items(15);
        configure(511, 300, 16383, 31, 63);
        random_items(20);
        repeat (2) begin
            configure($urandom_range(1, 100), $urandom_range(150, 256),
                      $urandom_range(1, 8192), $urandom_range(1, 16), $urandom_range(1, 12));
            random_items(25);
        end
        configure(RST_COLS, RST_ROWS, RST_PPL, RST_GW, RST_GH);
        random_items(20);

        stop_sending();
        while (expected_rows.size() != 0) @(posedge i_clk);
        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
